// File: sv/fcca_pkg.sv
// Shared types and constants for the FAT32 cluster chain addresser.
package fcca_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_PARTITION_START  = 3'd0;
   localparam logic [2:0] REG_RESERVED_SECTORS = 3'd1;
   localparam logic [2:0] REG_FAT_COPIES       = 3'd2;
   localparam logic [2:0] REG_FAT_LENGTH       = 3'd3;
   localparam logic [2:0] REG_SECTOR_SIZE_LOG2 = 3'd4;
   localparam logic [2:0] REG_CLUSTER_SECTORS  = 3'd5;
   localparam logic [2:0] REG_ROOT_ENTRIES     = 3'd6;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_END      = 2'd1;
   localparam logic [1:0] STATUS_INVALID  = 2'd2;
   localparam logic [1:0] STATUS_NO_CHAIN = 2'd3;

   // Request kinds.
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_FAT_WORD = 1'b1;

   // FAT entry constants.
   localparam logic [31:0] CLUSTER_MASK  = 32'h0fff_ffff;
   localparam logic [27:0] END_OF_CHAIN  = 28'hfff_fff8;
   localparam logic [27:0] FIRST_CLUSTER = 28'd2;

   // Legal sector size range, as log2 of bytes.
   localparam logic [3:0] LG_MIN = 4'd9;
   localparam logic [3:0] LG_MAX = 4'd12;

   // Volume geometry terms precomputed from the configuration registers.
   typedef struct packed {
      logic [31:0] base_data;
      logic [31:0] base_fat;
      logic [3:0]  lg;
      logic [7:0]  cluster_sectors;
   } geom_type;

   // One result word.
   typedef struct packed {
      logic [1:0]  status;
      logic [27:0] chain_cluster;
      logic [31:0] data_sector;
      logic [31:0] fat_lba;
      logic [11:0] entry_offset;
   } result_type;

endpackage

// File: sv/fcca_geom.sv
// Configuration registers and the precomputed volume geometry terms.
module fcca_geom
   import fcca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output geom_type    geom
);

   logic [31:0] partition_start_ff;
   logic [15:0] reserved_sectors_ff;
   logic [7:0]  fat_copies_ff;
   logic [31:0] fat_length_ff;
   logic [3:0]  sector_size_log2_ff;
   logic [7:0]  cluster_sectors_ff;
   logic [15:0] root_entries_ff;

   geom_type    geom_ff;
   geom_type    geom_in;

   logic [3:0]  lg;
   logic [39:0] fat_area;
   logic [21:0] root_bytes;
   logic [21:0] sector_mask;
   logic [21:0] root_round;
   logic [21:0] root_sectors;

   always_ff @(posedge clock) begin
      if (reset) begin
         partition_start_ff  <= 32'd0;
         reserved_sectors_ff <= 16'd32;
         fat_copies_ff       <= 8'd2;
         fat_length_ff       <= 32'd0;
         sector_size_log2_ff <= 4'd9;
         cluster_sectors_ff  <= 8'd8;
         root_entries_ff     <= 16'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PARTITION_START:  partition_start_ff  <= csr_wdata;
            REG_RESERVED_SECTORS: reserved_sectors_ff <= csr_wdata[15:0];
            REG_FAT_COPIES:       fat_copies_ff       <= csr_wdata[7:0];
            REG_FAT_LENGTH:       fat_length_ff       <= csr_wdata;
            REG_SECTOR_SIZE_LOG2: sector_size_log2_ff <= csr_wdata[3:0];
            REG_CLUSTER_SECTORS:  cluster_sectors_ff  <= csr_wdata[7:0];
            REG_ROOT_ENTRIES:     root_entries_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Sector sizes outside 512 to 4096 bytes are clamped to the nearest end.
   always_comb begin
      if (sector_size_log2_ff < LG_MIN) begin
         lg = LG_MIN;
      end else if (sector_size_log2_ff > LG_MAX) begin
         lg = LG_MAX;
      end else begin
         lg = sector_size_log2_ff;
      end
   end

   // Root directory sectors: entries of 32 bytes, rounded up to whole sectors.
   assign fat_area     = 40'(fat_copies_ff) * 40'(fat_length_ff);
   assign root_bytes   = {1'b0, root_entries_ff, 5'b0_0000};
   assign sector_mask  = 22'((22'd1 << lg) - 22'd1);
   assign root_round   = root_bytes + sector_mask;
   assign root_sectors = root_round >> lg;

   always_comb begin
      geom_in.base_fat        = partition_start_ff + 32'(reserved_sectors_ff);
      geom_in.base_data       = geom_in.base_fat + fat_area[31:0] + 32'(root_sectors);
      geom_in.lg              = lg;
      geom_in.cluster_sectors = cluster_sectors_ff;
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

// File: sv/fcca_calc.sv
// Per-word classification and sector address arithmetic.
module fcca_calc
   import fcca_pkg::*;
(
   input  geom_type    geom,
   input  logic        req_type,
   input  logic [31:0] req_value,
   input  logic        chain_open,
   output result_type  result,
   output logic        chain_open_in
);

   logic [31:0] masked;
   logic [27:0] cl;
   logic [27:0] cl_rel;
   logic [35:0] cluster_offset;
   logic [31:0] entry_byte;

   assign masked         = req_value & CLUSTER_MASK;
   assign cl             = masked[27:0];
   assign cl_rel         = cl - FIRST_CLUSTER;
   assign cluster_offset = 36'(cl_rel) * 36'(geom.cluster_sectors);
   assign entry_byte     = {2'b00, cl, 2'b00};

   always_comb begin
      result.status        = STATUS_OK;
      result.chain_cluster = cl;
      result.data_sector   = 32'd0;
      result.fat_lba       = 32'd0;
      result.entry_offset  = 12'd0;
      chain_open_in        = chain_open;
      if (req_type == REQ_FAT_WORD && !chain_open) begin
         result.status        = STATUS_NO_CHAIN;
         result.chain_cluster = 28'd0;
      end else if (cl >= END_OF_CHAIN) begin
         result.status = STATUS_END;
         chain_open_in = 1'b0;
      end else if (cl < FIRST_CLUSTER) begin
         result.status = STATUS_INVALID;
         chain_open_in = 1'b0;
      end else begin
         chain_open_in       = 1'b1;
         result.data_sector  = geom.base_data + cluster_offset[31:0];
         result.fat_lba      = geom.base_fat + (entry_byte >> geom.lg);
         result.entry_offset = entry_byte[11:0] & ~(12'hfff << geom.lg);
      end
   end

endmodule

// File: sv/fat32_cluster_chain_addresser.sv
// Top level of the FAT32 cluster chain addresser: handshake pipeline and chain state.
// A word accepted into the input register moves on to the result register, which drives rsp_valid, once that has room.
// Throughput: one word per cycle while rsp_stall is low; the input register and the result register each hold one.
// Configuration takes effect for words accepted from the edge after the write onwards.
// Reset is synchronous and active high: it empties both registers, closes any open chain
// and restores the configuration registers to their documented defaults.
module fat32_cluster_chain_addresser
   import fcca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [27:0] rsp_chain_cluster,
   output logic [31:0] rsp_data_sector,
   output logic [31:0] rsp_fat_lba,
   output logic [11:0] rsp_entry_offset
);

   // The geometry unit keeps the configuration registers and folds every
   // cluster-independent term of the address sums into a registered base, so
   // that the per-word path holds only one small multiply, a subtract, a shift and two adds.
   geom_type    geom;

   // Input register: the word that is being worked on this cycle.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic        in_type_ff;
   logic [31:0] in_value_ff;

   // Result register, which drives the rsp_ ports directly.
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  out_ff;

   // A chain is open between a good cluster and the next end or bad word.
   logic        chain_open_ff;
   logic        chain_open_in;

   result_type  result;
   logic        out_ready;
   logic        advance;
   logic        req_accept;

   fcca_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   fcca_calc u_calc (
      .geom          (geom),
      .req_type      (in_type_ff),
      .req_value     (in_value_ff),
      .chain_open    (chain_open_ff),
      .result        (result),
      .chain_open_in (chain_open_in)
   );

   // The result register can take a new word when it is empty or is being
   // emptied in this cycle. The input word moves on whenever that is so, and
   // the input register can refill in the same cycle.
   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         chain_open_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // The chain state changes exactly when a word is resolved, so the
         // following word in the input register always sees it up to date.
         if (advance) begin
            chain_open_ff <= chain_open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff  <= req_type;
         in_value_ff <= req_value;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_chain_cluster = out_ff.chain_cluster;
   assign rsp_data_sector   = out_ff.data_sector;
   assign rsp_fat_lba       = out_ff.fat_lba;
   assign rsp_entry_offset  = out_ff.entry_offset;

`ifndef SYNTHESIS
   // A good cluster leaves a chain open for the next FAT word.
   assert property (@(posedge clock) disable iff (reset)
      advance && result.status == STATUS_OK |=> chain_open_ff)
      else $error("chain not open after a good cluster");

   // A word with no chain open leaves the chain state alone.
   assert property (@(posedge clock) disable iff (reset)
      advance && result.status == STATUS_NO_CHAIN |=> chain_open_ff == $past(chain_open_ff))
      else $error("chain state changed by an orphan FAT word");

   // Only a good cluster carries addresses.
   assert property (@(posedge clock) disable iff (reset)
      advance && result.status != STATUS_OK |=>
         rsp_data_sector == 32'd0 && rsp_fat_lba == 32'd0 && rsp_entry_offset == 12'd0)
      else $error("addresses given for a word that is not a good cluster");

   // The input side is held back only by a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && in_valid_ff)
      else $error("input stalled without back-pressure from the result side");
`endif

endmodule

// File: dv/fcca_chain_checker.sv
// Checker for the FAT32 cluster chain addresser: mirrors the chain state and compares results.
module fcca_chain_checker
   import fcca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [27:0] rsp_chain_cluster,
   input  logic [31:0] rsp_data_sector,
   input  logic [31:0] rsp_fat_lba,
   input  logic [11:0] rsp_entry_offset,
   output int          mismatches,
   output int          outstanding,
   output int          compared
);

   // Shadow copy of the volume geometry.
   logic [31:0] part_start;
   logic [15:0] rsvd_secs;
   logic [7:0]  copies;
   logic [31:0] fat_len;
   logic [3:0]  size_lg;
   logic [7:0]  clus_secs;
   logic [15:0] root_ents;

   logic        walk_open;
   result_type  expected_walk[$];

   // Works out the result of one accepted word and advances the chain state.
   function automatic result_type walk_step(input logic kind, input logic [31:0] word);
      result_type  r;
      logic [27:0] cl;
      logic [3:0]  lg;
      logic [31:0] c32, sec_bytes, root_secs, byte_pos;
      r  = '0;
      cl = word[27:0];
      if (kind == REQ_FAT_WORD && !walk_open) begin
         r.status = STATUS_NO_CHAIN;
         return r;
      end
      r.chain_cluster = cl;
      if (cl >= END_OF_CHAIN) begin
         walk_open = 1'b0;
         r.status  = STATUS_END;
         return r;
      end
      if (cl < FIRST_CLUSTER) begin
         walk_open = 1'b0;
         r.status  = STATUS_INVALID;
         return r;
      end
      walk_open = 1'b1;
      lg = (size_lg < LG_MIN) ? LG_MIN : ((size_lg > LG_MAX) ? LG_MAX : size_lg);
      sec_bytes = 32'd1 << lg;
      root_secs = ({16'd0, root_ents} * 32'd32 + sec_bytes - 32'd1) >> lg;
      c32       = {4'd0, cl};
      byte_pos  = c32 << 2;
      r.status      = STATUS_OK;
      r.data_sector = part_start + {16'd0, rsvd_secs} + {24'd0, copies} * fat_len
                      + root_secs + (c32 - 32'd2) * {24'd0, clus_secs};
      r.fat_lba     = part_start + {16'd0, rsvd_secs} + (byte_pos >> lg);
      byte_pos      = byte_pos & (sec_bytes - 32'd1);
      r.entry_offset = byte_pos[11:0];
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         part_start = 32'd0;
         rsvd_secs  = 16'd32;
         copies     = 8'd2;
         fat_len    = 32'd0;
         size_lg    = 4'd9;
         clus_secs  = 8'd8;
         root_ents  = 16'd0;
         walk_open  = 1'b0;
         expected_walk.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_PARTITION_START:  part_start = csr_wdata;
               REG_RESERVED_SECTORS: rsvd_secs  = csr_wdata[15:0];
               REG_FAT_COPIES:       copies     = csr_wdata[7:0];
               REG_FAT_LENGTH:       fat_len    = csr_wdata;
               REG_SECTOR_SIZE_LOG2: size_lg    = csr_wdata[3:0];
               REG_CLUSTER_SECTORS:  clus_secs  = csr_wdata[7:0];
               REG_ROOT_ENTRIES:     root_ents  = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_walk.size() == 0) begin
               $display("%0t: result word with nothing outstanding, status %0d cluster 0x%07h",
                        $time, rsp_status, rsp_chain_cluster);
               mismatches++;
            end else begin
               want = expected_walk.pop_front();
               compared++;
               if (rsp_status !== want.status)
                  report("status", {30'd0, want.status}, {30'd0, rsp_status});
               if (rsp_chain_cluster !== want.chain_cluster)
                  report("chain_cluster", {4'd0, want.chain_cluster},
                         {4'd0, rsp_chain_cluster});
               if (rsp_data_sector !== want.data_sector)
                  report("data_sector", want.data_sector, rsp_data_sector);
               if (rsp_fat_lba !== want.fat_lba)
                  report("fat_lba", want.fat_lba, rsp_fat_lba);
               if (rsp_entry_offset !== want.entry_offset)
                  report("entry_offset", {20'd0, want.entry_offset}, {20'd0, rsp_entry_offset});
            end
         end
         if (req_valid && !req_stall)
            expected_walk.push_back(walk_step(req_type, req_value));
      end
      outstanding = expected_walk.size();
   end

endmodule

// File: dv/tb.sv
// Testbench top for the FAT32 cluster chain addresser: stimulus, idling and the verdict.
module tb;
   import fcca_pkg::*;

   // Generous ceiling for the slowest legal run with long gaps on both sides.
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_WORDS = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [27:0] rsp_chain_cluster;
   logic [31:0] rsp_data_sector;
   logic [31:0] rsp_fat_lba;
   logic [11:0] rsp_entry_offset;

   int mismatches;
   int outstanding;
   int compared;
   int cycle_count = 0;
   int words_sent  = 0;
   int geometries  = 1;
   // When set, neither side idles, so the block sees back-to-back words.
   bit quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fat32_cluster_chain_addresser DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_chain_cluster (rsp_chain_cluster),
      .rsp_data_sector   (rsp_data_sector),
      .rsp_fat_lba       (rsp_fat_lba),
      .rsp_entry_offset  (rsp_entry_offset)
   );

   fcca_chain_checker walk_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_chain_cluster (rsp_chain_cluster),
      .rsp_data_sector   (rsp_data_sector),
      .rsp_fat_lba       (rsp_fat_lba),
      .rsp_entry_offset  (rsp_entry_offset),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .compared          (compared)
   );

   // Idle lengths: mostly none, now and then a long stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A cluster number that the block should accept, with the ignored top nibble
   // occasionally set. Small clusters keep the FAT sector arithmetic readable; the
   // others sit just below the end markers or spread over the whole 28-bit range.
   function automatic logic [31:0] pick_cluster();
      logic [31:0] w;
      logic [31:0] top;
      case ($urandom_range(0, 3))
         0: w = $urandom_range(2, 4095);
         1: w = {4'd0, END_OF_CHAIN} - $urandom_range(1, 64);
         default: w = $urandom_range(2, 32'h0fff_fff7);
      endcase
      top = $urandom();
      if ($urandom_range(0, 3) == 0)
         w[31:28] = top[3:0];
      return w;
   endfunction

   // Any of the eight end-of-chain markers, upper nibble at random.
   function automatic logic [31:0] pick_end_marker();
      logic [31:0] w;
      w = $urandom();
      return {w[31:28], END_OF_CHAIN | {25'd0, w[2:0]}};
   endfunction

   // Sends one word. The task is entered and left at a falling edge; valid stays high
   // into the next word when no gap is drawn, so it is never dropped and raised in one step.
   task automatic send_word(input logic kind, input logic [31:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= word;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every outstanding result has come back, then lets the
   // two-stage pipeline settle before anything touches the registers.
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // Writes the full geometry in one burst; write enable is only lowered at the end.
   task automatic write_geometry(input logic [31:0] ps, input logic [31:0] rs,
                                 input logic [31:0] fc, input logic [31:0] fl,
                                 input logic [31:0] lg, input logic [31:0] cs,
                                 input logic [31:0] re);
      csr_write(REG_PARTITION_START, ps);
      csr_write(REG_RESERVED_SECTORS, rs);
      csr_write(REG_FAT_COPIES, fc);
      csr_write(REG_FAT_LENGTH, fl);
      csr_write(REG_SECTOR_SIZE_LOG2, lg);
      csr_write(REG_CLUSTER_SECTORS, cs);
      csr_write(REG_ROOT_ENTRIES, re);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      geometries++;
   endtask

   // A geometry drawn at random, leaning towards the shapes real volumes have but
   // now and then straying into odd sector sizes, zero terms and large root areas.
   task automatic random_geometry();
      logic [31:0] lg, cs, fc, re;
      lg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(9, 12);
      cs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : (32'd1 << $urandom_range(0, 7));
      fc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 2);
      re = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : 32'd0;
      write_geometry($urandom(), $urandom_range(0, 65535), fc, $urandom(), lg, cs, re);
   endtask

   // Random traffic: mostly well-formed chains with random content, the rest stray
   // words of either kind, which also gives FAT words with no chain open.
   task automatic random_chains(input int quota);
      int stop_at, links, r;
      logic [31:0] w;
      stop_at = words_sent + quota;
      quiet = ($urandom_range(0, 3) == 0);
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            w = $urandom();
            send_word(w[0] ? REQ_FAT_WORD : REQ_START, $urandom());
         end else begin
            send_word(REQ_START, pick_cluster());
            links = $urandom_range(0, 12);
            repeat (links) send_word(REQ_FAT_WORD, pick_cluster());
            r = $urandom_range(0, 99);
            w = $urandom();
            if (r < 60)
               send_word(REQ_FAT_WORD, pick_end_marker());
            else if (r < 75)
               send_word(REQ_FAT_WORD, {w[31:28], 27'd0, w[0]});
            // Otherwise the chain is left open and the next start replaces it.
         end
      end
   endtask

   // The responder's stall: random holds that never abut one another, so
   // the stall line never gets two updates in one step.
   initial begin : stall_driver
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (1 + $urandom_range(0, 6)) @(negedge clock);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_type  = REQ_START;
      req_value = 32'd0;
      csr_wr_en = 1'b0;
      csr_index = REG_PARTITION_START;
      csr_wdata = 32'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words on the reset geometry, both sides idling at random.
      send_word(REQ_FAT_WORD, 32'h0000_1234);      // nothing open yet
      send_word(REQ_START, 32'd2);                 // lowest real cluster
      send_word(REQ_FAT_WORD, 32'd3);
      send_word(REQ_FAT_WORD, 32'h0fff_fff7);      // highest real cluster
      send_word(REQ_FAT_WORD, 32'hf000_0005);      // top nibble must be ignored
      send_word(REQ_FAT_WORD, 32'h0fff_fff8);      // lowest end marker closes the chain
      send_word(REQ_FAT_WORD, 32'hffff_ffff);      // and a word after it finds nothing open
      send_word(REQ_START, 32'h0fff_ffff);         // start on an end marker
      send_word(REQ_START, 32'd0);                 // clusters zero and one are invalid
      send_word(REQ_START, 32'd1);
      send_word(REQ_START, 32'd5);
      send_word(REQ_FAT_WORD, 32'h1000_0001);      // invalid link closes the chain
      send_word(REQ_FAT_WORD, 32'd0);
      send_word(REQ_START, 32'hffff_ffff);
      send_word(REQ_START, 32'h1000_0002);         // cluster two behind a set top nibble
      send_word(REQ_FAT_WORD, 32'h0000_0200);      // first entry of the fifth FAT sector
      send_word(REQ_FAT_WORD, 32'h0000_01ff);
      send_word(REQ_FAT_WORD, 32'hffff_ffff);
      send_word(REQ_START, 32'h0fff_fff7);
      send_word(REQ_FAT_WORD, 32'h0000_0000);

      // Every term at its maximum so the sums wrap, with an out-of-range sector size clamped to 4096 bytes.
      drain();
      write_geometry(32'hffff_ffff, 32'h0000_ffff, 32'h0000_00ff, 32'hffff_ffff,
                     32'h0000_000f, 32'h0000_00ff, 32'h0000_ffff);
      random_chains(PHASE_WORDS);

      // Every term zero, sector size clamped up to 512 bytes.
      drain();
      write_geometry(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      random_chains(PHASE_WORDS);

      // A plausible volume: one FAT copy, 4096-byte sectors, largest power-of-two cluster size.
      drain();
      write_geometry(32'd2048, 32'd32, 32'd1, 32'd7640, 32'd12, 32'd128, 32'd512);
      random_chains(PHASE_WORDS);

      repeat (5) begin
         drain();
         random_geometry();
         random_chains(PHASE_WORDS);
      end

      drain();
      $display("Covered %0d words over %0d geometry settings, %0d results compared,",
               words_sent, geometries, compared);
      $display("including chain ends, invalid clusters and stray FAT words under random stalls.");
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
